FILE: design/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

    localparam int MUL_CW  = 32;
    localparam int LATENCY = 10;
    localparam int REL_W   = 16;
    localparam int MIN_W   = 32;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 32;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SMALL     = 2'd2
    } t_status;

    typedef enum logic [CFG_IW-1:0] {
        CFG_REL_TOL = 2'd0,
        CFG_MIN_NSQ = 2'd1
    } t_cfg_idx;

endpackage

FILE: design/pit_mul.sv
`timescale 1ns / 1ps

module pit_mul #(
    parameter int AW = 25,
    parameter int BW = 25
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic [AW+BW-1:0]     o_p
);
    import pit_pkg::*;

    localparam int KA   = (AW + MUL_CW - 1) / MUL_CW;
    localparam int KB   = (BW + MUL_CW - 1) / MUL_CW;
    localparam int EAW  = KA * MUL_CW;
    localparam int EBW  = KB * MUL_CW;
    localparam int SUMW = EAW + EBW + 2;
    localparam int PPW  = 2 * MUL_CW + 2;

    logic signed [EAW-1:0]  w_a;
    logic signed [EBW-1:0]  w_b;
    logic signed [PPW-1:0]  r_pp [KA*KB];
    logic signed [SUMW-1:0] n_sum;
    logic [AW+BW-1:0]       r_p;

    assign w_a = EAW'(i_a);
    assign w_b = EBW'(i_b);

    // lower chunks are unsigned, the top chunk carries the sign
    for (genvar ia = 0; ia < KA; ia++) begin : g_a
        for (genvar ib = 0; ib < KB; ib++) begin : g_b
            logic signed [MUL_CW:0] w_ao;
            logic signed [MUL_CW:0] w_bo;
            assign w_ao = {(ia == KA - 1) ? w_a[(ia+1)*MUL_CW-1] : 1'b0,
                           w_a[ia*MUL_CW +: MUL_CW]};
            assign w_bo = {(ib == KB - 1) ? w_b[(ib+1)*MUL_CW-1] : 1'b0,
                           w_b[ib*MUL_CW +: MUL_CW]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pp[ia*KB+ib] <= w_ao * w_bo;
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < KA * KB; k++) begin
            n_sum = n_sum + (SUMW'(r_pp[k]) <<< (((k / KB) + (k % KB)) * MUL_CW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[AW+BW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

FILE: design/pit_cross.sv
`timescale 1ns / 1ps

module pit_cross #(
    parameter int COORD_BITS = 24
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [11:0][COORD_BITS-1:0]              i_coord,
    output logic [3:0][2:0][2*(COORD_BITS+1):0]      o_vec
);
    localparam int DIFW = COORD_BITS + 1;
    localparam int NW   = 2 * DIFW + 1;

    logic [4:0][2:0][DIFW-1:0]   r_d;
    logic [3:0][5:0][2*DIFW-1:0] r_p;
    logic [3:0][2:0][NW-1:0]     r_x;

    // edge vectors C-L, R-L and corner-to-point vectors L-P, C-P, R-P
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_d[0][j] <= DIFW'($signed(i_coord[3+j])) - DIFW'($signed(i_coord[j]));
                r_d[1][j] <= DIFW'($signed(i_coord[6+j])) - DIFW'($signed(i_coord[j]));
                r_d[2][j] <= DIFW'($signed(i_coord[j]))   - DIFW'($signed(i_coord[9+j]));
                r_d[3][j] <= DIFW'($signed(i_coord[3+j])) - DIFW'($signed(i_coord[9+j]));
                r_d[4][j] <= DIFW'($signed(i_coord[6+j])) - DIFW'($signed(i_coord[9+j]));
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_pair
        localparam int PU = (k == 0) ? 0 : (k == 1) ? 2 : (k == 2) ? 3 : 4;
        localparam int PV = (k == 0) ? 1 : (k == 1) ? 3 : (k == 2) ? 4 : 2;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k][0] <= $signed(r_d[PU][1]) * $signed(r_d[PV][2]);
                r_p[k][1] <= $signed(r_d[PU][2]) * $signed(r_d[PV][1]);
                r_p[k][2] <= $signed(r_d[PU][2]) * $signed(r_d[PV][0]);
                r_p[k][3] <= $signed(r_d[PU][0]) * $signed(r_d[PV][2]);
                r_p[k][4] <= $signed(r_d[PU][0]) * $signed(r_d[PV][1]);
                r_p[k][5] <= $signed(r_d[PU][1]) * $signed(r_d[PV][0]);
                r_x[k][0] <= NW'($signed(r_p[k][0])) - NW'($signed(r_p[k][1]));
                r_x[k][1] <= NW'($signed(r_p[k][2])) - NW'($signed(r_p[k][3]));
                r_x[k][2] <= NW'($signed(r_p[k][4])) - NW'($signed(r_p[k][5]));
            end
        end
    end

    assign o_vec = r_x;

endmodule

FILE: design/point_in_triangle_3d_check.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipe holds while a result waits
// under stall, and a new item enters in the same cycle the result leaves.
// Reset: synchronous active-low; clears all valid bits and loads the
// tolerance registers with 1678 and 43.
module point_in_triangle_3d_check #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_BITS-1:0]         i_left_x,
    input  logic [COORD_BITS-1:0]         i_left_y,
    input  logic [COORD_BITS-1:0]         i_left_z,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [COORD_BITS-1:0]         i_center_z,
    input  logic [COORD_BITS-1:0]         i_right_x,
    input  logic [COORD_BITS-1:0]         i_right_y,
    input  logic [COORD_BITS-1:0]         i_right_z,
    input  logic [COORD_BITS-1:0]         i_mv_x,
    input  logic [COORD_BITS-1:0]         i_mv_y,
    input  logic [COORD_BITS-1:0]         i_mv_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_inside_res,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pit_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [pit_pkg::CFG_DW-1:0]    i_cfg_data
);
    import pit_pkg::*;

    localparam int DIFW = COORD_BITS + 1;
    localparam int NW   = 2 * DIFW + 1;
    localparam int DW   = 2 * NW + 2;
    localparam int SW   = DW + 3;
    localparam int RW   = REL_W + 1 + DW;
    localparam int CMPW = SW + 26;
    localparam int LW   = DW + 32 + 4 * FRAC_BITS;

    logic                          w_en;
    logic [LATENCY-1:0]            r_vld;
    logic [REL_W-1:0]              r_rel_tol;
    logic [MIN_W-1:0]              r_min_nsq;
    logic [11:0][COORD_BITS-1:0]   w_coord;
    logic [3:0][2:0][NW-1:0]       w_vec;
    logic [3:0][2:0][2*NW-1:0]     w_prod;
    logic [3:0][DW-1:0]            n_dot;
    logic [3:0][DW-1:0]            r_dot;
    logic signed [SW-1:0]          n_s;
    t_status                       n_st7;
    logic signed [SW-1:0]          r7_s, r8_s, r9_s;
    logic signed [DW-1:0]          r7_n2, r8_n2, r9_n2;
    t_status                       r7_st, r8_st, r9_st;
    logic [RW-1:0]                 w_rhs;
    logic signed [SW:0]            n_diff;
    logic signed [CMPW-1:0]        n_lhs;
    logic signed [CMPW-1:0]        n_rhs;
    logic                          r_inside;
    t_status                       r_status;

    // advance everything unless a finished result is held by stall
    assign w_en    = !(r_vld[LATENCY-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_tol <= REL_W'(1678);
            r_min_nsq <= MIN_W'(43);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REL_TOL: r_rel_tol <= i_cfg_data[REL_W-1:0];
                CFG_MIN_NSQ: r_min_nsq <= i_cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_coord = {i_mv_z, i_mv_y, i_mv_x, i_right_z, i_right_y, i_right_x,
                      i_center_z, i_center_y, i_center_x, i_left_z, i_left_y, i_left_x};

    pit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_coord (w_coord),
        .o_vec   (w_vec)
    );

    // dot products of the normal with itself and with the three sub-triangle normals
    for (genvar k = 0; k < 4; k++) begin : g_dot
        for (genvar j = 0; j < 3; j++) begin : g_cmp
            pit_mul #(.AW(NW), .BW(NW)) u_mul (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   ($signed(w_vec[0][j])),
                .i_b   ($signed(w_vec[k][j])),
                .o_p   (w_prod[k][j])
            );
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_dot[k] = DW'($signed(w_prod[k][0])) + DW'($signed(w_prod[k][1]))
                     + DW'($signed(w_prod[k][2]));
        end
    end

    always_comb begin
        n_s = '0;
        for (int k = 1; k < 4; k++) begin
            if (r_dot[k][DW-1]) begin
                n_s = n_s - SW'($signed(r_dot[k]));
            end else begin
                n_s = n_s + SW'($signed(r_dot[k]));
            end
        end
        if (r_dot[0] == '0) begin
            n_st7 = ST_COLLINEAR;
        end else if ((LW'(r_dot[0]) << 32) < (LW'(r_min_nsq) << (4 * FRAC_BITS))) begin
            n_st7 = ST_SMALL;
        end else begin
            n_st7 = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dot <= n_dot;
            r7_s  <= n_s;
            r7_n2 <= $signed(r_dot[0]);
            r7_st <= n_st7;
            r8_s  <= r7_s;
            r8_n2 <= r7_n2;
            r8_st <= r7_st;
            r9_s  <= r8_s;
            r9_n2 <= r8_n2;
            r9_st <= r8_st;
        end
    end

    pit_mul #(.AW(REL_W + 1), .BW(DW)) u_rel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ($signed({1'b0, r_rel_tol})),
        .i_b   (r7_n2),
        .o_p   (w_rhs)
    );

    // (S - N2) * 2^24 <= tolerance * N2
    always_comb begin
        n_diff = (SW+1)'(r9_s) - (SW+1)'(r9_n2);
        n_lhs  = CMPW'(n_diff) <<< 24;
        n_rhs  = CMPW'($signed(w_rhs));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_status <= r9_st;
            r_inside <= (r9_st == ST_OK) && (n_lhs <= n_rhs);
        end
    end

    assign o_inside_res = r_inside;
    assign o_status     = r_status;

endmodule

FILE: design/pit_checker.sv
`timescale 1ns / 1ps

module pit_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_inside_res,
    input logic [1:0] o_status
);
    import pit_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_inside_res))
        else $error("result changed under stall");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output hold");

    a_bad_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_inside_res)
        else $error("inside reported for degenerate triangle");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind point_in_triangle_3d_check pit_checker u_pit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_inside_res (o_inside_res),
    .o_status     (o_status)
);
